### hw/rtl/u8vr_pkg.sv
// ----------------------------------------------------------------------------
// u8vr_pkg: shared types and constants
// Byte classes, queue entry layout and result helper for the UTF-8 repair unit.
// ----------------------------------------------------------------------------
package u8vr_pkg;

  localparam logic [7:0] AsciiMax    = 8'h7F;
  localparam logic [7:0] ContMin     = 8'h80;
  localparam logic [7:0] ContMax     = 8'hBF;
  localparam logic [7:0] BadLeadMax  = 8'hC1;
  localparam logic [7:0] Lead2Max    = 8'hDF;
  localparam logic [7:0] Lead3Max    = 8'hEF;
  localparam logic [7:0] Lead4Max    = 8'hF4;
  localparam logic [7:0] BadLeadMin  = 8'hF5;
  localparam logic [7:0] ReplByte    = 8'h3F;

  localparam int unsigned HeldDepth  = 3;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       inv;
  } ent_t;

  // one group of results caused by one input byte; last_idx = count - 1
  typedef struct packed {
    logic [1:0]                  last_idx;
    ent_t [MaxResults-1:0]       ent;
  } grp_t;

  function automatic ent_t mk_ent(logic [7:0] b, logic bad, logic repl, logic inv);
    ent_t e;
    e.data = (bad && repl) ? ReplByte : b;
    e.bad  = bad;
    e.inv  = inv;
    return e;
  endfunction

endpackage

### hw/rtl/u8vr_front.sv
// ----------------------------------------------------------------------------
// u8vr_front: byte classifier and sequence tracker
// Accepts one byte per beat while the queue has room, tracks the pending
// sequence and builds the group of results that the byte causes.
// ----------------------------------------------------------------------------
module u8vr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  logic               q_full_i,
  output logic               in_ready_o,
  output logic               q_push_o,
  output u8vr_pkg::grp_t     q_grp_o
);
  import u8vr_pkg::*;

  logic                              replace_q;
  logic [HeldDepth-1:0][7:0]         hb_q, hb_d;
  logic [1:0]                        hc_q, hc_d;
  logic [1:0]                        nc_q, nc_d;
  logic                              err_q, err_d;

  logic       accept;
  logic       is_cont, bad_lead;
  logic [1:0] lead_need;
  logic       flush_a, good_a, b_emit, b_bad, fresh;
  logic [2:0] cnt;
  grp_t       grp;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign is_cont   = (in_byte_i >= ContMin) && (in_byte_i <= ContMax);
  assign bad_lead  = ((in_byte_i >= ContMin) && (in_byte_i <= BadLeadMax)) ||
                     (in_byte_i >= BadLeadMin);
  assign lead_need = (in_byte_i <= Lead2Max) ? 2'd1 :
                     (in_byte_i <= Lead3Max) ? 2'd2 : 2'd3;

  always_comb begin
    hb_d    = hb_q;
    hc_d    = hc_q;
    nc_d    = nc_q;
    err_d   = err_q;
    flush_a = 1'b0;
    good_a  = 1'b0;
    b_emit  = 1'b0;
    b_bad   = 1'b0;
    fresh   = 1'b0;
    cnt     = '0;
    grp     = '0;

    if (hc_q != 2'd0) begin
      if (is_cont) begin
        if (nc_q <= 2'd1) begin
          good_a = 1'b1;
          b_emit = 1'b1;
          hc_d   = 2'd0;
          nc_d   = 2'd0;
        end else begin
          if (hc_q != 2'd3) begin
            hb_d[hc_q] = in_byte_i;
          end
          hc_d = hc_q + 2'd1;
          nc_d = nc_q - 2'd1;
        end
      end else begin
        flush_a = 1'b1;
        fresh   = 1'b1;
        hc_d    = 2'd0;
        nc_d    = 2'd0;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (in_byte_i <= AsciiMax) begin
        b_emit = 1'b1;
      end else if (bad_lead) begin
        b_emit = 1'b1;
        b_bad  = 1'b1;
      end else begin
        // Lead4Max is the top of the lead range left after the bad-lead test
        hb_d[0] = in_byte_i;
        hc_d    = 2'd1;
        nc_d    = (in_byte_i <= Lead4Max) ? lead_need : 2'd3;
      end
    end

    for (int i = 0; i < HeldDepth; i++) begin
      if ((flush_a || good_a) && (2'(i) < hc_q)) begin
        err_d = err_d | flush_a;
        if (cnt != 3'(MaxResults)) begin
          grp.ent[cnt[1:0]] = mk_ent(hb_q[i], flush_a, replace_q, err_d);
        end
        cnt = cnt + 3'd1;
      end
    end

    if (b_emit) begin
      err_d = err_d | b_bad;
      if (cnt != 3'(MaxResults)) begin
        grp.ent[cnt[1:0]] = mk_ent(in_byte_i, b_bad, replace_q, err_d);
      end
      cnt = cnt + 3'd1;
    end

    if (in_last_i) begin
      for (int i = 0; i < HeldDepth; i++) begin
        if (2'(i) < hc_d) begin
          err_d = 1'b1;
          if (cnt != 3'(MaxResults)) begin
            grp.ent[cnt[1:0]] = mk_ent(hb_d[i], 1'b1, replace_q, err_d);
          end
          cnt = cnt + 3'd1;
        end
      end
    end

    grp.last_idx = 2'(cnt - 3'd1);
  end

  assign q_push_o = accept && (cnt != 3'd0);
  assign q_grp_o  = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_q <= 1'b1;
      hc_q      <= 2'd0;
      nc_q      <= 2'd0;
      err_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        replace_q <= cfg_data_i;
      end
      if (accept) begin
        if (in_last_i) begin
          hc_q  <= 2'd0;
          nc_q  <= 2'd0;
          err_q <= 1'b0;
        end else begin
          hc_q  <= hc_d;
          nc_q  <= nc_d;
          err_q <= err_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hb_q <= hb_d;
    end
  end

endmodule

### hw/rtl/u8vr_queue.sv
// ----------------------------------------------------------------------------
// u8vr_queue: result group queue
// Two-entry queue of result groups between the classifier and the emitter.
// ----------------------------------------------------------------------------
module u8vr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  u8vr_pkg::grp_t     grp_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output u8vr_pkg::grp_t     grp_o
);
  import u8vr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  grp_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign grp_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= grp_i;
    end
  end

endmodule

### hw/rtl/u8vr_back.sv
// ----------------------------------------------------------------------------
// u8vr_back: result emitter
// Walks the head group one result per unstalled beat into the output register.
// ----------------------------------------------------------------------------
module u8vr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  u8vr_pkg::grp_t     q_grp_i,
  output logic               q_pop_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [7:0]         m_data_o,
  output logic [1:0]         m_user_o,
  output logic               m_last_o
);
  import u8vr_pkg::*;

  logic [1:0] idx_q;
  logic       vld_q;
  ent_t       ent_q;
  logic       last_q;
  logic       load, at_end;

  assign load    = q_valid_i && (!vld_q || m_ready_i);
  assign at_end  = (idx_q == q_grp_i.last_idx);
  assign q_pop_o = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (m_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q  <= q_grp_i.ent[idx_q];
      last_q <= at_end;
    end
  end

  assign m_valid_o = vld_q;
  assign m_data_o  = ent_q.data;
  assign m_user_o  = {ent_q.inv, ent_q.bad};
  assign m_last_o  = last_q;

endmodule

### hw/rtl/utf8_validate_and_repair_unit.sv
// ----------------------------------------------------------------------------
// utf8_validate_and_repair_unit: streaming UTF-8 validator and repairer
// One input byte per beat while the queue has room; results are the bytes of
// complete sequences unchanged and the bytes of broken sequences marked bad
// (optionally '?').
// A byte is accepted every cycle while the two-entry group queue has room.
// Each byte yields zero to four result beats, which leave one per cycle from
// the output register unless m_axis_tready stalls it; plain ASCII runs at one
// byte per cycle when the output is not stalled, each byte passing through a
// queue entry and the output register. The replace_enable register (reset 1)
// must be written through the cfg port only while the unit is idle; the unit
// itself does not enforce this. tlast on the input ends a stream: pending
// bytes are flushed as bad and the sticky invalid flag clears for the next stream.
module utf8_validate_and_repair_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,      // replace_enable
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic [1:0] m_axis_tuser,    // [0] out_bad, [1] stream_invalid
  output logic       m_axis_tlast
);
  import u8vr_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  grp_t grp_in, grp_head;

  assign cfg_ready_o = 1'b1;

  u8vr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .q_push_o    (q_push),
    .q_grp_o     (grp_in)
  );

  u8vr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .grp_i   (grp_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .grp_o   (grp_head)
  );

  u8vr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_grp_i   (grp_head),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

### hw/rtl/u8vr_checker.sv
// ----------------------------------------------------------------------------
// u8vr_checker: port-level checks
// Observes the top-level ports and flags inconsistent result beats.
// ----------------------------------------------------------------------------
module u8vr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // a bad byte sets the sticky flag on its own beat
  a_bad_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
    else $error("bad beat without stream_invalid");

  // bad bytes are never ASCII: either replaced or with the top bit set
  a_bad_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == 8'h3F) || m_axis_tdata[7])
    else $error("bad beat carries an ASCII byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

endmodule

bind utf8_validate_and_repair_unit u8vr_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
